// ===== rtl/lpsp_pkg.sv =====
// Shared types, constants and helper functions of the LED tile scan driver.
package lpsp_pkg;

  localparam int TILES_ACROSS = 9;
  localparam int TILE_ROWS    = 4;
  localparam int PWM_SLOTS    = 16;
  localparam int SLOT_W       = $clog2(PWM_SLOTS);
  localparam int GRID_TILES   = TILES_ACROSS * TILE_ROWS;

  localparam logic [7:0] HDR_PIXEL   = 8'h42;
  localparam logic [7:0] HDR_FRAME   = 8'h23;
  localparam logic [7:0] HDR_ESCAPE  = 8'h65;
  localparam logic [7:0] HDR_COMMAND = 8'h66;
  localparam logic [7:0] CMD_LOCATE  = 8'hff;
  localparam logic [7:0] MAX_LEVEL   = 8'h0f;

  localparam logic [0:0] REG_PANEL_INDEX = 1'd0;
  localparam logic [0:0] REG_DWELL_UNIT  = 1'd1;
  localparam logic [10:0] DWELL_RESET    = 11'd80;

  localparam logic [2:0] FILL_LAST   = 3'd7;
  localparam logic [4:0] COMMIT_LAST = 5'd31;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PIXEL   = 2'd1,
    MODE_FRAME   = 2'd2,
    MODE_COMMAND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FILL   = 2'd1,
    ST_COMMIT = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       busy;
    logic       fill;
    logic       commit;
    logic [4:0] step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_fill;
    logic start_commit;
  } dp_stat_t;

  // Grid row of the tile, valid for positions inside the grid.
  function automatic logic [2:0] tile_row_of(input logic [5:0] panel);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (int'(panel) >= i * TILES_ACROSS) r = 3'(i);
    end
    return r;
  endfunction

  // Grid column of the tile, valid for positions inside the grid.
  function automatic logic [3:0] tile_col_of(input logic [5:0] panel);
    logic [9:0] base;
    base = 10'(tile_row_of(panel)) * 10'(TILES_ACROSS);
    return 4'(10'(panel) - base);
  endfunction

  function automatic logic [5:0] slot_weight(input logic [SLOT_W-1:0] s);
    logic [5:0] w;
    w = 6'd1;
    if (int'(s) < 16) begin
      unique case (4'(s))
        4'd5:    w = 6'd2;
        4'd6:    w = 6'd3;
        4'd7:    w = 6'd4;
        4'd8:    w = 6'd6;
        4'd9:    w = 6'd7;
        4'd10:   w = 6'd11;
        4'd11:   w = 6'd18;
        4'd12:   w = 6'd30;
        4'd13:   w = 6'd50;
        4'd14:   w = 6'd4;
        default: w = 6'd1;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== rtl/lpsp_ctrl.sv =====
// Sequencer that runs the set-all sweep and the frame commit sweep.
module lpsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  lpsp_pkg::dp_stat_t  stat,
  output lpsp_pkg::ctrl_cmd_t cmd
);
  import lpsp_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = 5'd0;
        if (stat.start_fill) state_nxt = ST_FILL;
        else if (stat.start_commit) state_nxt = ST_COMMIT;
      end
      ST_FILL: begin
        step_nxt = step_r + 5'd1;
        if (step_r[2:0] == FILL_LAST) state_nxt = ST_IDLE;
      end
      ST_COMMIT: begin
        step_nxt = step_r + 5'd1;
        if (step_r == COMMIT_LAST) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.step   = step_r;
    unique case (state_r)
      ST_IDLE:   cmd.busy = 1'b0;
      ST_FILL: begin
        cmd.busy = 1'b1;
        cmd.fill = 1'b1;
      end
      ST_COMMIT: begin
        cmd.busy   = 1'b1;
        cmd.commit = 1'b1;
      end
      default:   cmd.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 5'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && step_r[2:0] == FILL_LAST) |=> state_r == ST_IDLE)
    else $error("fill sweep did not end after eight rows");
  a_commit_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && step_r != COMMIT_LAST) |=> state_r == ST_COMMIT)
    else $error("commit sweep stopped early");
  a_commit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && stat.start_commit && !stat.start_fill)
      |=> (state_r == ST_COMMIT && step_r == 5'd0))
    else $error("commit sweep did not start at step zero");
`endif

endmodule

// ===== rtl/lpsp_dp.sv =====
// Byte parser, pixel and staging stores, and PWM scan output stage.
module lpsp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lpsp_pkg::ctrl_cmd_t cmd,
  output lpsp_pkg::dp_stat_t  stat,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [10:0]         cfg_wdata,
  input  logic                byte_acc,
  input  logic                tick_acc,
  input  logic [7:0]          in_byte_value,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_scan_row,
  output logic [7:0]          out_column_mask,
  output logic                out_row_start,
  output logic [3:0]          out_slot,
  output logic [15:0]         out_dwell
);
  import lpsp_pkg::*;

  logic [5:0]  panel_r, panel_nxt;
  logic [10:0] unit_r, unit_nxt;
  logic [31:0] pix_r [8];
  logic [31:0] pix_nxt [8];
  logic [7:0]  stage_r [32];
  logic        stage_we;
  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [1:0]  pfi_r, pfi_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [1:0]  fbl_r, fbl_nxt;
  logic [3:0]  ftc_r, ftc_nxt;
  logic [2:0]  fl_r, fl_nxt, ftr_r, ftr_nxt;
  logic [3:0]  fill_lvl_r, fill_lvl_nxt;
  logic        locate_r, locate_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [2:0]  row_r, row_nxt;

  logic [7:0]  d, px, py;
  logic [3:0]  lvl, tcol;
  logic [2:0]  trow;
  logic        in_grid, hit, pix_we;
  logic [7:0]  sbyte;
  logic [31:0] fill_row;
  logic [7:0]  mask;
  logic [16:0] prod;

  logic        ov_r;
  logic [2:0]  orow_r;
  logic [7:0]  omask_r;
  logic        ostart_r;
  logic [3:0]  oslot_r;
  logic [15:0] odwell_r;

  assign in_grid = int'(panel_r) < GRID_TILES;
  assign trow    = tile_row_of(panel_r);
  assign tcol    = tile_col_of(panel_r);
  assign px      = x_r - 8'd1;
  assign py      = y_r - 8'd1;
  assign hit     = in_grid && (px[7:3] == 5'(tcol))
                   && (py[7:3] == 5'(3'(TILE_ROWS - 1) - trow));

  // Parser: header decode, escape remap and per-mode field handling.
  always_comb begin
    mode_nxt     = mode_r;
    esc_nxt      = esc_r;
    pfi_nxt      = pfi_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    fbl_nxt      = fbl_r;
    ftc_nxt      = ftc_r;
    fl_nxt       = fl_r;
    ftr_nxt      = ftr_r;
    fill_lvl_nxt = fill_lvl_r;
    locate_nxt   = locate_r;
    stat         = '0;
    stage_we     = 1'b0;
    pix_we       = 1'b0;
    d            = in_byte_value;
    lvl          = (in_byte_value > MAX_LEVEL) ? 4'hf : in_byte_value[3:0];
    if (byte_acc) begin
      priority if (in_byte_value == HDR_PIXEL) begin
        mode_nxt = MODE_PIXEL;
        pfi_nxt  = 2'd0;
      end else if (in_byte_value == HDR_FRAME) begin
        mode_nxt = MODE_FRAME;
        fbl_nxt  = 2'd0;
        ftc_nxt  = 4'd0;
        fl_nxt   = 3'd0;
        ftr_nxt  = 3'(TILE_ROWS - 1);
      end else if (in_byte_value == HDR_ESCAPE) begin
        esc_nxt = 1'b1;
      end else if (in_byte_value == HDR_COMMAND) begin
        mode_nxt = MODE_COMMAND;
      end else begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          priority case (in_byte_value)
            8'd1:    d = HDR_FRAME;
            8'd2:    d = HDR_PIXEL;
            8'd3:    d = HDR_ESCAPE;
            8'd4:    d = HDR_COMMAND;
            default: d = in_byte_value;
          endcase
        end
        lvl = (d > MAX_LEVEL) ? 4'hf : d[3:0];
        unique case (mode_r)
          MODE_PIXEL: begin
            priority case (pfi_r)
              2'd0: begin
                x_nxt   = d;
                pfi_nxt = 2'd1;
              end
              2'd1: begin
                y_nxt   = d;
                pfi_nxt = 2'd2;
              end
              default: begin
                if (x_r == 8'd0 && y_r == 8'd0) begin
                  stat.start_fill = 1'b1;
                  fill_lvl_nxt    = lvl;
                  locate_nxt      = 1'b0;
                end else if (hit) begin
                  pix_we = 1'b1;
                end
                pfi_nxt  = 2'd3;
                mode_nxt = MODE_IDLE;
              end
            endcase
          end
          MODE_FRAME: begin
            stage_we = in_grid && (ftc_r == tcol) && (ftr_r == trow);
            fbl_nxt  = fbl_r + 2'd1;
            if (fbl_r == 2'd3) begin
              ftc_nxt = ftc_r + 4'd1;
              if (ftc_r == 4'(TILES_ACROSS - 1)) begin
                ftc_nxt = 4'd0;
                fl_nxt  = fl_r + 3'd1;
                if (fl_r == 3'd7) begin
                  if (ftr_r == 3'd0) begin
                    stat.start_commit = in_grid;
                    mode_nxt          = MODE_IDLE;
                  end else begin
                    ftr_nxt = ftr_r - 3'd1;
                  end
                end
              end
            end
          end
          MODE_COMMAND: begin
            if (d == CMD_LOCATE) begin
              stat.start_fill = 1'b1;
              fill_lvl_nxt    = 4'd0;
              locate_nxt      = 1'b1;
            end
            mode_nxt = MODE_IDLE;
          end
          default: mode_nxt = MODE_IDLE;
        endcase
      end
    end
  end

  // Pixel store updates: one row per fill step, two nibbles per commit step, else a single pixel write.
  always_comb begin
    fill_row = {8{fill_lvl_r}};
    if (locate_r && cmd.step[2:0] == panel_r[5:3]) fill_row[{panel_r[2:0], 2'b00} +: 4] = 4'hf;
    sbyte = stage_r[cmd.step];
    for (int r = 0; r < 8; r++) pix_nxt[r] = pix_r[r];
    priority if (cmd.fill) begin
      pix_nxt[cmd.step[2:0]] = fill_row;
    end else if (cmd.commit) begin
      pix_nxt[{~cmd.step[1:0], 1'b1}][{~cmd.step[4:2], 2'b00} +: 4] = sbyte[3:0];
      pix_nxt[{~cmd.step[1:0], 1'b0}][{~cmd.step[4:2], 2'b00} +: 4] = sbyte[7:4];
    end else if (pix_we) begin
      pix_nxt[~px[2:0]][{~py[2:0], 2'b00} +: 4] = lvl;
    end
  end

  // Scan slot: lit columns, saturated dwell and slot/row advance; configuration register writes.
  always_comb begin
    mask = 8'd0;
    if (slot_r != SLOT_W'(PWM_SLOTS - 1)) begin
      for (int c = 0; c < 8; c++) mask[c] = int'(pix_r[row_r][c*4 +: 4]) > int'(slot_r);
    end
    prod     = 17'(unit_r) * 17'(slot_weight(slot_r));
    slot_nxt = slot_r;
    row_nxt  = row_r;
    if (tick_acc) begin
      if (slot_r == SLOT_W'(PWM_SLOTS - 1)) begin
        slot_nxt = '0;
        row_nxt  = row_r + 3'd1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    panel_nxt = panel_r;
    unit_nxt  = unit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PANEL_INDEX: panel_nxt = cfg_wdata[5:0];
        REG_DWELL_UNIT:  unit_nxt  = cfg_wdata;
        default:         unit_nxt  = unit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_r    <= 6'd0;
      unit_r     <= DWELL_RESET;
      for (int r = 0; r < 8; r++) pix_r[r] <= 32'd0;
      mode_r     <= MODE_IDLE;
      esc_r      <= 1'b0;
      pfi_r      <= 2'd0;
      x_r        <= 8'd0;
      y_r        <= 8'd0;
      fbl_r      <= 2'd0;
      ftc_r      <= 4'd0;
      fl_r       <= 3'd0;
      ftr_r      <= 3'd0;
      fill_lvl_r <= 4'd0;
      locate_r   <= 1'b0;
      slot_r     <= '0;
      row_r      <= 3'd0;
      ov_r       <= 1'b0;
    end else begin
      panel_r    <= panel_nxt;
      unit_r     <= unit_nxt;
      for (int r = 0; r < 8; r++) pix_r[r] <= pix_nxt[r];
      mode_r     <= mode_nxt;
      esc_r      <= esc_nxt;
      pfi_r      <= pfi_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      fbl_r      <= fbl_nxt;
      ftc_r      <= ftc_nxt;
      fl_r       <= fl_nxt;
      ftr_r      <= ftr_nxt;
      fill_lvl_r <= fill_lvl_nxt;
      locate_r   <= locate_nxt;
      slot_r     <= slot_nxt;
      row_r      <= row_nxt;
      if (tick_acc) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_we) stage_r[{fl_r, fbl_r}] <= d;
    if (tick_acc) begin
      orow_r   <= row_r;
      omask_r  <= mask;
      ostart_r <= (slot_r == '0);
      oslot_r  <= 4'(slot_r);
      odwell_r <= prod[16] ? 16'hffff : prod[15:0];
    end
  end

  assign out_valid       = ov_r;
  assign out_scan_row    = orow_r;
  assign out_column_mask = omask_r;
  assign out_row_start   = ostart_r;
  assign out_slot        = oslot_r;
  assign out_dwell       = odwell_r;

endmodule

// ===== rtl/led_panel_stream_and_pwm_scan.sv =====
// Top level of the LED tile driver: serial byte parser and weighted PWM row scan.
//
// The input channel (in_valid, in_stall, in_cmd, in_byte_value) carries one beat
// per received serial byte (in_cmd low) or per scan tick (in_cmd high).
// A byte beat produces no result. A tick beat produces exactly one result beat
// on the output channel: the row being driven, the lit-column mask, a row-start
// flag for slot 0, the slot index and the slot dwell in timer counts.
// A tick result appears in the output register in the cycle after acceptance.
// A set-all pixel write or a locate command sweeps the eight pixel rows,
// holding in_stall high while it runs; for an in-grid tile the final byte of a
// full frame commits the staged tile at two pixels a cycle, also holding
// in_stall high. The length of these sweeps is set by the single row write port of
// the pixel store and the single read of the staging buffer per cycle.
// While a result waits under out_stall, in_stall stays high so no new beat
// enters. The configuration port (cfg_we, cfg_index, cfg_wdata) writes the
// tile position and the dwell unit, and should only be used while idle.
// Synchronous reset darkens every pixel, returns the parser to idle, restarts
// the scan at row 0 slot 0 and sets the dwell unit to 80.
module led_panel_stream_and_pwm_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_scan_row,
  output logic [7:0]  out_column_mask,
  output logic        out_row_start,
  output logic [3:0]  out_slot,
  output logic [15:0] out_dwell
);
  import lpsp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      accept, byte_acc, tick_acc;

  // Hold off input while a sweep runs or a result is still waiting.
  assign in_stall = cmd.busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign byte_acc = accept & ~in_cmd;
  assign tick_acc = accept & in_cmd;

  lpsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  lpsp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .byte_acc        (byte_acc),
    .tick_acc        (tick_acc),
    .in_byte_value   (in_byte_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_scan_row    (out_scan_row),
    .out_column_mask (out_column_mask),
    .out_row_start   (out_row_start),
    .out_slot        (out_slot),
    .out_dwell       (out_dwell)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.busy |-> !(accept))
    else $error("beat accepted during a sweep");
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> out_valid)
    else $error("tick produced no result");
  a_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && !out_valid) |=> !out_valid)
    else $error("byte produced a result");
`endif

endmodule

// ===== dv/lpsp_checker.sv =====
// Scoreboard for the LED tile driver: mirrors the parser and scan state and checks each result beat.
module lpsp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_scan_row,
  input  logic [7:0]  out_column_mask,
  input  logic        out_row_start,
  input  logic [3:0]  out_slot,
  input  logic [15:0] out_dwell,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpsp_pkg::*;

  typedef struct {
    logic [2:0]  row;
    logic [7:0]  mask;
    logic        first;
    logic [3:0]  slot;
    logic [15:0] dwell;
  } scan_beat_t;

  localparam int SLOT_WEIGHTS [16] = '{1, 1, 1, 1, 1, 2, 3, 4, 6, 7, 11, 18, 30, 50, 4, 1};

  scan_beat_t scan_expect_q[$];

  logic [3:0]  level_mem [64];
  logic [7:0]  frame_buf [32];
  mode_t       mode;
  logic        esc;
  int          field_idx;
  logic [7:0]  x_latch, y_latch;
  int          f_byte, f_col, f_line, f_row;
  int          scan_slot, scan_row;
  logic [5:0]  panel;
  logic [10:0] unit;

  assign pending = scan_expect_q.size();

  task automatic set_level(input int row, input int col, input int lvl);
    level_mem[(row & 7) * 8 + (col & 7)] = (lvl > 15) ? 4'd15 : 4'(lvl);
  endtask

  task automatic set_every(input int lvl);
    for (int i = 0; i < 64; i++) set_level(i / 8, i % 8, lvl);
  endtask

  function automatic bit on_grid();
    return int'(panel) < GRID_TILES;
  endfunction

  task automatic take_pixel_byte(input logic [7:0] d);
    logic [7:0] px, py;
    int ox, oy;
    if (field_idx == 0) begin
      x_latch = d;
      field_idx = 1;
    end else if (field_idx == 1) begin
      y_latch = d;
      field_idx = 2;
    end else begin
      if (x_latch == 0 && y_latch == 0) begin
        set_every(d);
      end else if (on_grid()) begin
        px = x_latch - 8'd1;
        py = y_latch - 8'd1;
        ox = (int'(panel) % TILES_ACROSS) * 8;
        oy = (TILE_ROWS - 1 - int'(panel) / TILES_ACROSS) * 8;
        if (int'(px) >= ox && int'(px) < ox + 8 && int'(py) >= oy && int'(py) < oy + 8)
          set_level(7 - (int'(px) - ox), 7 - (int'(py) - oy), d);
      end
      field_idx = 3;
      mode = MODE_IDLE;
    end
  endtask

  task automatic take_frame_byte(input logic [7:0] d);
    if (on_grid() && f_col == int'(panel) % TILES_ACROSS &&
        f_row == int'(panel) / TILES_ACROSS)
      frame_buf[(f_line & 7) * 4 + (f_byte & 3)] = d;
    f_byte++;
    if (f_byte < 4) return;
    f_byte = 0;
    f_col++;
    if (f_col < TILES_ACROSS) return;
    f_col = 0;
    f_line++;
    if (f_line < 8) return;
    f_line = 0;
    if (f_row == 0) begin
      // The whole frame has arrived: two pixels per staged byte.
      if (on_grid()) begin
        for (int ln = 0; ln < 8; ln++) begin
          for (int k = 0; k < 4; k++) begin
            set_level(7 - 2 * k, 7 - ln, frame_buf[ln * 4 + k][3:0]);
            set_level(6 - 2 * k, 7 - ln, frame_buf[ln * 4 + k][7:4]);
          end
        end
      end
      mode = MODE_IDLE;
    end else begin
      f_row--;
    end
  endtask

  task automatic take_serial_byte(input logic [7:0] b);
    logic [7:0] d;
    d = b;
    if (d == HDR_PIXEL) begin
      mode = MODE_PIXEL;
      field_idx = 0;
      return;
    end
    if (d == HDR_FRAME) begin
      mode = MODE_FRAME;
      f_byte = 0;
      f_col = 0;
      f_line = 0;
      f_row = TILE_ROWS - 1;
      return;
    end
    if (d == HDR_ESCAPE) begin
      esc = 1'b1;
      return;
    end
    if (d == HDR_COMMAND) begin
      mode = MODE_COMMAND;
      return;
    end
    if (esc) begin
      esc = 1'b0;
      case (d)
        8'd1: d = HDR_FRAME;
        8'd2: d = HDR_PIXEL;
        8'd3: d = HDR_ESCAPE;
        8'd4: d = HDR_COMMAND;
        default: ;
      endcase
    end
    case (mode)
      MODE_PIXEL: take_pixel_byte(d);
      MODE_FRAME: take_frame_byte(d);
      MODE_COMMAND: begin
        if (d == CMD_LOCATE) begin
          set_every(0);
          set_level(int'(panel) / 8, int'(panel) % 8, 15);
        end
        mode = MODE_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_scan_tick();
    scan_beat_t e;
    int prod;
    e.row = 3'(scan_row);
    e.slot = 4'(scan_slot);
    e.first = (scan_slot == 0);
    e.mask = '0;
    if (scan_slot != PWM_SLOTS - 1)
      for (int c = 0; c < 8; c++)
        if (int'(level_mem[scan_row * 8 + c]) > scan_slot) e.mask[c] = 1'b1;
    prod = int'(unit) * SLOT_WEIGHTS[scan_slot];
    e.dwell = (prod > 65535) ? 16'hffff : 16'(prod);
    scan_expect_q.push_back(e);
    scan_slot++;
    if (scan_slot >= PWM_SLOTS) begin
      scan_slot = 0;
      scan_row = (scan_row + 1) & 7;
    end
  endtask

  always @(posedge clk) begin
    scan_beat_t e;
    if (!rst_n) begin
      foreach (level_mem[i]) level_mem[i] = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      mode = MODE_IDLE;
      esc = 1'b0;
      field_idx = 0;
      x_latch = '0;
      y_latch = '0;
      f_byte = 0;
      f_col = 0;
      f_line = 0;
      f_row = 0;
      scan_slot = 0;
      scan_row = 0;
      panel = '0;
      unit = DWELL_RESET;
      fail_count = 0;
      scan_expect_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PANEL_INDEX) panel = cfg_wdata[5:0];
        else unit = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (in_cmd) predict_scan_tick();
        else take_serial_byte(in_byte_value);
      end
      if (out_valid && !out_stall) begin
        if (scan_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat, row %0d slot %0d",
                                         out_scan_row, out_slot);
        end else begin
          e = scan_expect_q.pop_front();
          if (out_scan_row !== e.row || out_column_mask !== e.mask ||
              out_row_start !== e.first || out_slot !== e.slot || out_dwell !== e.dwell) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp row %0d mask %h start %0d slot %0d dwell %0d, got %0d %h %0d %0d %0d",
                       e.row, e.mask, e.first, e.slot, e.dwell, out_scan_row,
                       out_column_mask, out_row_start, out_slot, out_dwell);
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the LED tile driver: stimulus, back-pressure and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpsp_pkg::*;

  // Far above the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_wdata;
  logic        in_valid, in_stall, in_cmd;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_scan_row;
  logic [7:0]  out_column_mask;
  logic        out_row_start;
  logic [3:0]  out_slot;
  logic [15:0] out_dwell;
  int          fail_count, pending;

  // Idling percentages of the current phase, and the handshake for the long hold-off.
  int          send_gap_pct, recv_stall_pct;
  bit          hold_req;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          cur_panel;

  led_panel_stream_and_pwm_scan DUT (.*);

  lpsp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver side. Random stalls per phase, plus one long hold-off that lets the
  // result register fill and pushes back on the input channel.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
      if (hold_left == 1) hold_done <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One beat on the input channel, with optional idle cycles in front of it.
  // The stall is looked at mid-cycle, where it holds the value the next edge sees.
  task automatic send_beat(input logic cmd, input logic [7:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_byte_value <= value;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_beat(1'b0, value);
  endtask

  task automatic tick();
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // Payload byte of a message; header values go out in escaped form.
  task automatic send_escaped(input logic [7:0] value);
    case (value)
      HDR_FRAME:   begin send_byte(HDR_ESCAPE); send_byte(8'd1); end
      HDR_PIXEL:   begin send_byte(HDR_ESCAPE); send_byte(8'd2); end
      HDR_ESCAPE:  begin send_byte(HDR_ESCAPE); send_byte(8'd3); end
      HDR_COMMAND: begin send_byte(HDR_ESCAPE); send_byte(8'd4); end
      default:     send_byte(value);
    endcase
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [10:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PANEL_INDEX) cur_panel = int'(value);
  endtask

  // Drains every result, then leaves room for a frame commit still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Pixel write aimed inside this tile most of the time.
  task automatic pixel_message();
    int ox, oy;
    logic [7:0] x, y;
    ox = (cur_panel % TILES_ACROSS) * 8;
    oy = (TILE_ROWS - 1 - cur_panel / TILES_ACROSS) * 8;
    if ($urandom_range(99) < 70) begin
      x = 8'(ox + 1 + $urandom_range(7));
      y = 8'(oy + 1 + $urandom_range(7));
    end else begin
      x = 8'($urandom_range(255));
      y = 8'($urandom_range(255));
    end
    send_byte(HDR_PIXEL);
    send_escaped(x);
    send_escaped(y);
    send_escaped(8'($urandom_range(255)));
  endtask

  // A complete, well-formed frame for the whole grid with ticks mixed in.
  task automatic frame_message();
    send_byte(HDR_FRAME);
    for (int i = 0; i < TILES_ACROSS * 4 * 8 * TILE_ROWS; i++) begin
      if ($urandom_range(99) < 5) tick();
      send_escaped(8'($urandom_range(255)));
    end
  endtask

  task automatic random_traffic(input int n_msgs);
    int pick;
    for (int i = 0; i < n_msgs; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) tick();
      else if (pick < 60) pixel_message();
      else if (pick < 65) begin
        send_byte(HDR_PIXEL);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 71) begin
        send_byte(HDR_COMMAND);
        send_byte(($urandom_range(1) != 0) ? CMD_LOCATE : 8'($urandom_range(255)));
      end else if (pick < 78) begin
        send_byte(HDR_ESCAPE);
        send_byte(8'($urandom_range(5)));
      end else begin
        // Noise, including headers that cut a message short.
        send_byte(8'($urandom_range(255)));
      end
    end
    // Leave the parser idle so a later register write never splits a frame.
    send_byte(HDR_COMMAND);
    send_byte(8'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PANEL_INDEX;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_byte_value = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    cur_panel = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings (tile 0: grid x 1..8, y 25..32).
    tick();
    send_byte(HDR_PIXEL); send_byte(8'd0); send_byte(8'd0); send_byte(8'hff);
    tick(); tick();
    send_byte(HDR_PIXEL); send_byte(8'd1); send_byte(8'd25); send_byte(8'd15);
    send_byte(HDR_PIXEL); send_byte(8'd8); send_byte(8'd32); send_byte(8'd0);
    tick();
    send_byte(HDR_COMMAND); send_byte(CMD_LOCATE);
    tick();
    send_byte(HDR_COMMAND); send_byte(8'h12);
    // An escape in idle is used up by the next plain byte.
    send_byte(HDR_ESCAPE); send_byte(8'd2);
    // A header while escaped acts as a header; the escape then remaps a coordinate.
    send_byte(HDR_ESCAPE); send_byte(HDR_PIXEL); send_byte(8'd1);
    send_byte(8'd30); send_byte(8'd9);
    tick();
    wait_drained();

    // Phase without idling, in-grid corner tile, dwell unit of 1.
    write_reg(REG_PANEL_INDEX, 11'd35);
    write_reg(REG_DWELL_UNIT, 11'd1);
    random_traffic(50);
    wait_drained();

    // Sender idles; the receiver holds off once for a long stretch.
    send_gap_pct = 62;
    write_reg(REG_PANEL_INDEX, 11'd0);
    write_reg(REG_DWELL_UNIT, 11'd1310);
    random_traffic(30);
    hold_req = 1'b1;
    random_traffic(30);
    while (!hold_done) @(posedge clk);
    // Sender pauses until every result is back.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    random_traffic(30);
    wait_drained();

    // Receiver stalls; tile outside the grid.
    send_gap_pct = 0;
    recv_stall_pct = 62;
    write_reg(REG_PANEL_INDEX, 11'd40);
    write_reg(REG_DWELL_UNIT, 11'd80);
    random_traffic(50);
    wait_drained();

    // Both sides idle; a middle tile receives a full frame.
    send_gap_pct = 30;
    recv_stall_pct = 30;
    write_reg(REG_PANEL_INDEX, 11'd13);
    write_reg(REG_DWELL_UNIT, 11'd777);
    frame_message();
    random_traffic(40);
    wait_drained();

    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
